// File: hw/rtl/wto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_pkg: shared types and constants of the wavetable oscillator
// Table geometry, register codes, waveform codes and the quarter-wave sine ROM
// built at elaboration from an odd Taylor polynomial in Q30.
// ----------------------------------------------------------------------------
package wto_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int FRAC_BITS  = 16;

	// Log2 of the largest power of two not above TABLE_SIZE
	localparam int IDX_W   = $clog2(TABLE_SIZE + 1) - 1;
	localparam int QTR_W   = IDX_W - 2;
	localparam int QUARTER = 1 << QTR_W;
	localparam int REM_W   = 32 - IDX_W;

	localparam int PHASE_W     = 32;
	localparam int SAMPLE_W    = 16;
	localparam int DIFF_W      = SAMPLE_W + 1;
	localparam int PROD_W      = FRAC_BITS + DIFF_W + 1;
	localparam int SUM_W       = SAMPLE_W + 2;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd19477829;

	localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SHAPE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 8'd1;

	typedef enum logic [1:0] {
		SHAPE_SINE   = 2'd0,
		SHAPE_TRI    = 2'd1,
		SHAPE_SQUARE = 2'd2,
		SHAPE_SAW    = 2'd3
	} shape_t;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	localparam logic [63:0] SIN_C1 = 64'd1686629713;
	localparam logic [63:0] SIN_C3 = 64'd693598668;
	localparam logic [63:0] SIN_C5 = 64'd85569306;
	localparam logic [63:0] SIN_C7 = 64'd5026995;
	localparam logic [63:0] SIN_C9 = 64'd172272;

	typedef logic [SAMPLE_W-2:0] sine_rom_t [QUARTER];

	// Sine magnitude of a Q30 quarter-wave position, rounded to Q15, capped
	function automatic logic [SAMPLE_W-2:0] sine_mag(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] r;
		t2 = (t * t) >> 30;
		p  = SIN_C9;
		p  = SIN_C7 - ((t2 * p) >> 30);
		p  = SIN_C5 - ((t2 * p) >> 30);
		p  = SIN_C3 - ((t2 * p) >> 30);
		p  = SIN_C1 - ((t2 * p) >> 30);
		s  = (t * p) >> 30;
		r  = (s + 64'd16384) >> 15;
		return (r > 64'd32767) ? 15'h7fff : r[SAMPLE_W-2:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < QUARTER; i++) begin
			rom[i] = sine_mag(64'(i) << (30 - QTR_W));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam logic [SAMPLE_W-2:0] SINE_PEAK = sine_mag(64'd1 << 30);

endpackage

// File: hw/rtl/wto_wave_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_wave_entry: one waveform table entry
// Returns the Q1.15 value of entry idx for the selected shape: sine from the
// quarter-wave ROM, triangle, square and saw computed from the index.
// ----------------------------------------------------------------------------
module wto_wave_entry (
	input  wto_pkg::shape_t                              shape,
	input  logic [wto_pkg::IDX_W-1:0]                    idx,
	output logic signed [wto_pkg::SAMPLE_W-1:0]          value
);

	logic [1:0]                       quad;
	logic [wto_pkg::QTR_W-1:0]        r;
	logic [wto_pkg::QTR_W-1:0]        r_mirror;
	logic                             at_peak;
	logic [wto_pkg::SAMPLE_W-2:0]     mag;
	logic signed [wto_pkg::SAMPLE_W-1:0] sine_val;
	logic [wto_pkg::IDX_W:0]          down;
	logic [wto_pkg::IDX_W+15:0]       tri_up_w;
	logic [wto_pkg::IDX_W+16:0]       tri_dn_w;
	logic [wto_pkg::IDX_W+15:0]       saw_w;
	logic [16:0]                      tri_dn;
	logic [15:0]                      saw;
	logic signed [wto_pkg::SAMPLE_W-1:0] tri_val;
	logic signed [wto_pkg::SAMPLE_W-1:0] sq_val;
	logic signed [wto_pkg::SAMPLE_W-1:0] saw_val;

	// Sine: mirror odd quadrants, negate the second half
	assign quad     = idx[wto_pkg::IDX_W-1 -: 2];
	assign r        = idx[wto_pkg::QTR_W-1:0];
	assign r_mirror = -r;
	assign at_peak  = quad[0] && (r == '0);

	always_comb begin
		if (at_peak) begin
			mag = wto_pkg::SINE_PEAK;
		end else begin
			mag = wto_pkg::SINE_ROM[quad[0] ? r_mirror : r];
		end
		sine_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	// Distance to the end of the table, N - idx
	assign down     = {1'b1, {wto_pkg::IDX_W{1'b0}}} - {1'b0, idx};
	assign tri_up_w = {idx, 16'b0};
	assign tri_dn_w = {down, 16'b0};
	assign saw_w    = {down, 15'b0};
	assign tri_dn   = tri_dn_w[wto_pkg::IDX_W+16:wto_pkg::IDX_W];
	assign saw      = saw_w[wto_pkg::IDX_W+15:wto_pkg::IDX_W];

	always_comb begin
		if (!idx[wto_pkg::IDX_W-1]) begin
			tri_val = $signed(tri_up_w[wto_pkg::IDX_W+15:wto_pkg::IDX_W]);
		end else if (tri_dn[16:15] != 2'b00) begin
			tri_val = wto_pkg::SAMPLE_MAX;
		end else begin
			tri_val = $signed(tri_dn[15:0]);
		end

		if (idx[wto_pkg::IDX_W-2:0] == '0) begin
			sq_val = '0;
		end else if (!idx[wto_pkg::IDX_W-1]) begin
			sq_val = wto_pkg::SAMPLE_MAX;
		end else begin
			sq_val = wto_pkg::SAMPLE_MIN;
		end

		saw_val = saw[15] ? wto_pkg::SAMPLE_MAX : $signed(saw);
	end

	always_comb begin
		case (shape)
			wto_pkg::SHAPE_SINE:   value = sine_val;
			wto_pkg::SHAPE_TRI:    value = tri_val;
			wto_pkg::SHAPE_SQUARE: value = sq_val;
			wto_pkg::SHAPE_SAW:    value = saw_val;
			default:               value = sine_val;
		endcase
	end

endmodule

// File: hw/rtl/wto_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wto_interp: linear interpolation between two table entries
// a + floor((b - a) * frac / 2^FRAC_BITS + 1/2), saturated to Q1.15.
// ----------------------------------------------------------------------------
module wto_interp (
	input  logic signed [wto_pkg::SAMPLE_W-1:0] a,
	input  logic signed [wto_pkg::DIFF_W-1:0]   diff,
	input  logic [wto_pkg::FRAC_BITS-1:0]       frac,
	output logic signed [wto_pkg::SAMPLE_W-1:0] sample
);

	localparam logic signed [wto_pkg::PROD_W-1:0] ROUND_HALF =
		$signed(wto_pkg::PROD_W'(1) << (wto_pkg::FRAC_BITS - 1));

	logic signed [wto_pkg::PROD_W-1:0] prod;
	logic signed [wto_pkg::PROD_W-1:0] rounded;
	logic signed [wto_pkg::SUM_W-1:0]  step;
	logic signed [wto_pkg::SUM_W-1:0]  sum;

	assign prod    = diff * $signed({1'b0, frac});
	assign rounded = prod + ROUND_HALF;
	// Arithmetic shift keeps the floor for negative slopes
	assign step    = rounded[wto_pkg::PROD_W-1:wto_pkg::FRAC_BITS];
	assign sum     = wto_pkg::SUM_W'(a) + step;

	always_comb begin
		if (sum > wto_pkg::SUM_W'(wto_pkg::SAMPLE_MAX)) begin
			sample = wto_pkg::SAMPLE_MAX;
		end else if (sum < wto_pkg::SUM_W'(wto_pkg::SAMPLE_MIN)) begin
			sample = wto_pkg::SAMPLE_MIN;
		end else begin
			sample = sum[wto_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

// File: hw/rtl/wavetable_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_oscillator: phase-accumulator oscillator with table interpolation
// Throughput: one input transfer and one sample per cycle while the output is
// not held by m_axis_tready; every stage of the three registered stages (read
// position, table entries, interpolated sample) loads in the same cycle that it hands its item on.
// Reset clears the phase accumulator and the pipeline, loads wave_shape = sine
// and the default phase_step; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wavetable_oscillator (
	input  logic                              clk,
	input  logic                              arst_n,

	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wto_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wto_pkg::CFG_DATA_W-1:0]    cfg_data,

	// Input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [wto_pkg::PHASE_W-1:0]       s_axis_tdata,   // [31:0] freq_offset (signed)

	// Output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [wto_pkg::SAMPLE_W-1:0]      m_axis_tdata    // [15:0] sample (signed Q1.15)
);

	// Configuration registers
	wto_pkg::shape_t                  wave_shape_q;
	logic [wto_pkg::PHASE_W-1:0]      phase_step_q;

	// Phase accumulator
	logic [wto_pkg::PHASE_W-1:0]      phase_acc_q;

	// Pipeline control
	logic                             vld_s1;
	logic                             vld_s2;
	logic                             vld_s3;
	logic                             adv_s1;
	logic                             adv_s2;
	logic                             adv_s3;
	logic                             in_xfer;

	// Pipeline payload
	logic [wto_pkg::PHASE_W-1:0]             rd_s1;
	logic signed [wto_pkg::SAMPLE_W-1:0]     a_s2;
	logic signed [wto_pkg::DIFF_W-1:0]       diff_s2;
	logic [wto_pkg::FRAC_BITS-1:0]           frac_s2;
	logic signed [wto_pkg::SAMPLE_W-1:0]     sample_s3;

	// Stage 1 to 2 datapath
	logic [wto_pkg::IDX_W-1:0]               idx;
	logic [wto_pkg::IDX_W-1:0]               idx_next;
	logic [wto_pkg::REM_W+wto_pkg::FRAC_BITS-1:0] rem_wide;
	logic [wto_pkg::FRAC_BITS-1:0]           frac;
	logic signed [wto_pkg::SAMPLE_W-1:0]     entry_a;
	logic signed [wto_pkg::SAMPLE_W-1:0]     entry_b;
	logic signed [wto_pkg::SAMPLE_W-1:0]     interp_sample;

	// ------------------------------------------------------------------
	// Configuration: always ready. The user writes only while idle; the block
	// has no interlock to enforce it. Unknown indexes are dropped.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q <= wto_pkg::SHAPE_SINE;
			phase_step_q <= wto_pkg::PHASE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wto_pkg::CFG_WAVE_SHAPE: wave_shape_q <= wto_pkg::shape_t'(cfg_data[1:0]);
				wto_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Elastic pipeline: each stage loads when it is empty or when the stage
	// after it moves on, so a waiting output sample does not block intake
	// while an earlier stage has room.
	// ------------------------------------------------------------------
	assign adv_s3        = !vld_s3 || m_axis_tready;
	assign adv_s2        = !vld_s2 || adv_s3;
	assign adv_s1        = !vld_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// Advance the accumulator by step plus per-transfer offset, mod 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (in_xfer) begin
			phase_acc_q <= phase_acc_q + phase_step_q + s_axis_tdata;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: read position is the negated phase before this transfer
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rd_s1 <= -phase_acc_q;
		end
	end

	// Top bits pick the entry, the following bits weight the next one.
	// Missing low fraction bits (wide tables) read as zero.
	assign idx      = rd_s1[wto_pkg::PHASE_W-1 -: wto_pkg::IDX_W];
	assign idx_next = idx + 1'b1;
	assign rem_wide = {rd_s1[wto_pkg::REM_W-1:0], {wto_pkg::FRAC_BITS{1'b0}}};
	assign frac     = rem_wide[wto_pkg::REM_W+wto_pkg::FRAC_BITS-1 -: wto_pkg::FRAC_BITS];

	wto_wave_entry u_entry_a (
		.shape (wave_shape_q),
		.idx   (idx),
		.value (entry_a)
	);

	wto_wave_entry u_entry_b (
		.shape (wave_shape_q),
		.idx   (idx_next),
		.value (entry_b)
	);

	// ------------------------------------------------------------------
	// Stage 2: hold the base entry, slope and fraction
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			a_s2    <= entry_a;
			diff_s2 <= wto_pkg::DIFF_W'(entry_b) - wto_pkg::DIFF_W'(entry_a);
			frac_s2 <= frac;
		end
	end

	wto_interp u_interp (
		.a      (a_s2),
		.diff   (diff_s2),
		.frac   (frac_s2),
		.sample (interp_sample)
	);

	// ------------------------------------------------------------------
	// Stage 3: output register, held until the downstream transfer
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			sample_s3 <= interp_sample;
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = sample_s3;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// Intake stalls only when every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && vld_s3 && !m_axis_tready))
		else $error("intake stalled with room in the pipeline");

	// Phase moves only on an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> $stable(phase_acc_q))
		else $error("phase accumulator moved without an input transfer");

	// An accepted item occupies stage 1 on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> vld_s1)
		else $error("accepted item lost at stage 1");

	// A new output sample comes from a filled stage 2
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(vld_s2))
		else $error("output valid without a stage 2 item");

endmodule
